### rtl/ray_axis_rectangle_intersect_unit_defines.svh
// Assertion macros used by the ray/rectangle intersection RTL.
`ifndef RAY_AXIS_RECTANGLE_INTERSECT_UNIT_DEFINES_SVH
`define RAY_AXIS_RECTANGLE_INTERSECT_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RARI_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RARI_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

### rtl/rari_pkg.sv
// Types and constants shared by the ray/rectangle intersection RTL.
package rari_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned CFG_IDX_W = 3;

  // Plane normal axis codes; code 3 is unused and always misses.
  typedef enum logic [1:0] {
    PLANE_XY = 2'd0,
    PLANE_XZ = 2'd1,
    PLANE_YZ = 2'd2
  } plane_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PLANE_AXIS   = 3'd0,
    CFG_PLANE_OFFSET = 3'd1,
    CFG_FIRST_LOW    = 3'd2,
    CFG_FIRST_HIGH   = 3'd3,
    CFG_SECOND_LOW   = 3'd4,
    CFG_SECOND_HIGH  = 3'd5
  } cfg_idx_e;

  // Ray data and flags that ride alongside the divider.
  typedef struct packed {
    logic                     miss;
    logic                     neg;
    logic                     front;
    logic signed [WORD_W-1:0] org_x;
    logic signed [WORD_W-1:0] org_y;
    logic signed [WORD_W-1:0] org_z;
    logic signed [WORD_W-1:0] dir_x;
    logic signed [WORD_W-1:0] dir_y;
    logic signed [WORD_W-1:0] dir_z;
    logic signed [WORD_W-1:0] t_min;
    logic signed [WORD_W-1:0] t_max;
  } side_t;

endpackage

### rtl/rari_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module rari_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic [rari_pkg::WORD_W-1:0]         rem_i,
  input  logic [rari_pkg::WORD_W-1:0]         lo_i,
  input  logic [rari_pkg::WORD_W-1:0]         den_i,
  input  rari_pkg::side_t                     side_i,
  output logic                                valid_o,
  output logic [rari_pkg::WORD_W-1:0]         quo_o,
  output rari_pkg::side_t                     side_o
);

  localparam int unsigned W = rari_pkg::WORD_W;
  localparam int unsigned N = rari_pkg::DIV_STEPS;

  logic                 vld_q  [N];
  logic [W-1:0]         rem_q  [N];
  logic [W-1:0]         lo_q   [N];
  logic [W-1:0]         den_q  [N];
  logic [W-1:0]         quo_q  [N];
  rari_pkg::side_t      side_q [N];

  for (genvar i = 0; i < N; i++) begin : g_step
    logic            vld_in;
    logic [W-1:0]    rem_in;
    logic [W-1:0]    lo_in;
    logic [W-1:0]    den_in;
    logic [W-1:0]    quo_in;
    rari_pkg::side_t side_in;
    logic [W:0]      trial;
    logic            fits;

    if (i == 0) begin : g_head
      assign vld_in  = valid_i;
      assign rem_in  = rem_i;
      assign lo_in   = lo_i;
      assign den_in  = den_i;
      assign quo_in  = '0;
      assign side_in = side_i;
    end else begin : g_body
      assign vld_in  = vld_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign lo_in   = lo_q[i-1];
      assign den_in  = den_q[i-1];
      assign quo_in  = quo_q[i-1];
      assign side_in = side_q[i-1];
    end

    // Bring down the next dividend bit and try the subtract.
    assign trial = {rem_in, lo_in[W-1]};
    assign fits  = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= fits ? W'(trial - {1'b0, den_in}) : trial[W-1:0];
        lo_q[i]   <= {lo_in[W-2:0], 1'b0};
        den_q[i]  <= den_in;
        quo_q[i]  <= {quo_in[W-2:0], fits};
        side_q[i] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[N-1];
  assign quo_o   = quo_q[N-1];
  assign side_o  = side_q[N-1];

endmodule

### rtl/ray_axis_rectangle_intersect_unit.sv
// Ray versus axis-aligned rectangle intersection, signed fixed point, fully pipelined.
// An input beat passes stages 1 and 2, the 32-stage restoring divider for t, stages 3 to 6
// and the output register. Throughput: one ray per cycle while the skid entry is empty.
// A two-entry output (register plus skid) lets the pipeline run while a result waits.
// Reset: asynchronous, active low; clears all valid bits and zeroes the rectangle registers.
`include "ray_axis_rectangle_intersect_unit_defines.svh"
module ray_axis_rectangle_intersect_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // rectangle register writes
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [rari_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [rari_pkg::WORD_W-1:0]           cfg_data_i,
  // ray input channel
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [rari_pkg::WORD_W-1:0]    origin_x_i,
  input  logic signed [rari_pkg::WORD_W-1:0]    origin_y_i,
  input  logic signed [rari_pkg::WORD_W-1:0]    origin_z_i,
  input  logic signed [rari_pkg::WORD_W-1:0]    dir_x_i,
  input  logic signed [rari_pkg::WORD_W-1:0]    dir_y_i,
  input  logic signed [rari_pkg::WORD_W-1:0]    dir_z_i,
  input  logic signed [rari_pkg::WORD_W-1:0]    t_min_i,
  input  logic signed [rari_pkg::WORD_W-1:0]    t_max_i,
  // result channel
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  hit_o,
  output logic signed [rari_pkg::WORD_W-1:0]    hit_t_o,
  output logic signed [rari_pkg::WORD_W-1:0]    point_x_o,
  output logic signed [rari_pkg::WORD_W-1:0]    point_y_o,
  output logic signed [rari_pkg::WORD_W-1:0]    point_z_o,
  output logic                                  front_face_o
);

  localparam int unsigned W    = rari_pkg::WORD_W;
  localparam int unsigned PW   = 2 * W;            // exact product / point width
  localparam int unsigned NW   = W + 1 + FRAC_BITS; // shifted numerator magnitude

  typedef struct packed {
    logic                hit;
    logic signed [W-1:0] t;
    logic signed [W-1:0] px;
    logic signed [W-1:0] py;
    logic signed [W-1:0] pz;
    logic                front;
  } res_t;

  // ---------------------------------------------------------------------------
  // Rectangle registers. Writes are always taken; unknown indexes are dropped.
  // ---------------------------------------------------------------------------
  logic [1:0]          plane_axis_q;
  logic signed [W-1:0] plane_offset_q;
  logic signed [W-1:0] first_low_q;
  logic signed [W-1:0] first_high_q;
  logic signed [W-1:0] second_low_q;
  logic signed [W-1:0] second_high_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_axis_q   <= '0;
      plane_offset_q <= '0;
      first_low_q    <= '0;
      first_high_q   <= '0;
      second_low_q   <= '0;
      second_high_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        rari_pkg::CFG_PLANE_AXIS:   plane_axis_q   <= cfg_data_i[1:0];
        rari_pkg::CFG_PLANE_OFFSET: plane_offset_q <= cfg_data_i;
        rari_pkg::CFG_FIRST_LOW:    first_low_q    <= cfg_data_i;
        rari_pkg::CFG_FIRST_HIGH:   first_high_q   <= cfg_data_i;
        rari_pkg::CFG_SECOND_LOW:   second_low_q   <= cfg_data_i;
        rari_pkg::CFG_SECOND_HIGH:  second_high_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Global advance: the whole pipeline holds only while the skid entry is full.
  logic en;
  logic skid_v_q;
  assign en         = !skid_v_q;
  assign in_stall_o = skid_v_q;

  // ---------------------------------------------------------------------------
  // Stage 1: pick the normal axis, form the numerator exactly, take magnitudes.
  // ---------------------------------------------------------------------------
  logic signed [W-1:0] org_n;
  logic signed [W-1:0] dir_n;
  logic                axis_bad;
  logic signed [W:0]   num;
  logic [W:0]          num_mag;

  always_comb begin
    axis_bad = 1'b0;
    case (plane_axis_q)
      rari_pkg::PLANE_XY: begin org_n = origin_z_i; dir_n = dir_z_i; end
      rari_pkg::PLANE_XZ: begin org_n = origin_y_i; dir_n = dir_y_i; end
      rari_pkg::PLANE_YZ: begin org_n = origin_x_i; dir_n = dir_x_i; end
      default: begin
        org_n    = '0;
        dir_n    = '0;
        axis_bad = 1'b1;
      end
    endcase
    num     = (W+1)'(plane_offset_q) - (W+1)'(org_n);
    num_mag = num[W] ? (W+1)'(-num) : num;
  end

  logic            s1_v_q;
  logic [W:0]      s1_num_q;
  logic [W-1:0]    s1_den_q;
  rari_pkg::side_t s1_side_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_num_q        <= num_mag;
      // two's complement negate gives the right unsigned magnitude, even for -2^31
      s1_den_q        <= dir_n[W-1] ? W'(-dir_n) : dir_n;
      s1_side_q.miss  <= axis_bad || (dir_n == '0);
      s1_side_q.neg   <= num[W] ^ dir_n[W-1];
      s1_side_q.front <= dir_n[W-1];
      s1_side_q.org_x <= origin_x_i;
      s1_side_q.org_y <= origin_y_i;
      s1_side_q.org_z <= origin_z_i;
      s1_side_q.dir_x <= dir_x_i;
      s1_side_q.dir_y <= dir_y_i;
      s1_side_q.dir_z <= dir_z_i;
      s1_side_q.t_min <= t_min_i;
      s1_side_q.t_max <= t_max_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: scale the numerator and screen quotients of 2^32 and up, so the
  // divider only has to produce 32 bits.
  // ---------------------------------------------------------------------------
  logic [NW-1:0]   num_sh;
  logic [W-1:0]    num_hi;
  logic            big_q;
  rari_pkg::side_t s2_side;

  assign num_sh = {s1_num_q, {FRAC_BITS{1'b0}}};
  assign num_hi = W'(num_sh[NW-1:W]);
  assign big_q  = num_hi >= s1_den_q;

  always_comb begin
    s2_side      = s1_side_q;
    s2_side.miss = s1_side_q.miss || big_q;
  end

  logic            s2_v_q;
  logic [W-1:0]    s2_rem_q;
  logic [W-1:0]    s2_lo_q;
  logic [W-1:0]    s2_den_q;
  rari_pkg::side_t s2_side_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_rem_q  <= num_hi;
      s2_lo_q   <= num_sh[W-1:0];
      s2_den_q  <= s1_den_q;
      s2_side_q <= s2_side;
    end
  end

  // ---------------------------------------------------------------------------
  // Divider: 32 stages, one quotient bit each.
  // ---------------------------------------------------------------------------
  logic            dv_v;
  logic [W-1:0]    dv_quo;
  rari_pkg::side_t dv_side;

  rari_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s2_v_q),
    .rem_i   (s2_rem_q),
    .lo_i    (s2_lo_q),
    .den_i   (s2_den_q),
    .side_i  (s2_side_q),
    .valid_o (dv_v),
    .quo_o   (dv_quo),
    .side_o  (dv_side)
  );

  // ---------------------------------------------------------------------------
  // Stage 3: apply the sign, drop quotients outside signed 32 bits, test [t_min, t_max].
  // ---------------------------------------------------------------------------
  logic signed [W-1:0] t_val;
  logic                t_ovf;
  rari_pkg::side_t     s3_side;

  always_comb begin
    if (dv_side.neg) begin
      t_ovf = dv_quo > {1'b1, {(W-1){1'b0}}};
      t_val = W'(-dv_quo);
    end else begin
      t_ovf = dv_quo[W-1];
      t_val = dv_quo;
    end
    s3_side      = dv_side;
    s3_side.miss = dv_side.miss || t_ovf ||
                   (t_val < dv_side.t_min) || (t_val > dv_side.t_max);
  end

  logic                s3_v_q;
  logic signed [W-1:0] s3_t_q;
  rari_pkg::side_t     s3_side_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_t_q    <= t_val;
      s3_side_q <= s3_side;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: exact products t * dir for all three axes.
  // ---------------------------------------------------------------------------
  logic                 s4_v_q;
  logic signed [W-1:0]  s4_t_q;
  logic signed [PW-1:0] s4_px_q;
  logic signed [PW-1:0] s4_py_q;
  logic signed [PW-1:0] s4_pz_q;
  rari_pkg::side_t      s4_side_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_t_q    <= s3_t_q;
      s4_px_q   <= s3_t_q * s3_side_q.dir_x;
      s4_py_q   <= s3_t_q * s3_side_q.dir_y;
      s4_pz_q   <= s3_t_q * s3_side_q.dir_z;
      s4_side_q <= s3_side_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: hit point = origin + floor(product / 2^FRAC_BITS), full precision.
  // ---------------------------------------------------------------------------
  logic                 s5_v_q;
  logic signed [W-1:0]  s5_t_q;
  logic signed [PW-1:0] s5_x_q;
  logic signed [PW-1:0] s5_y_q;
  logic signed [PW-1:0] s5_z_q;
  rari_pkg::side_t      s5_side_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_t_q    <= s4_t_q;
      s5_x_q    <= PW'(s4_side_q.org_x) + (s4_px_q >>> FRAC_BITS);
      s5_y_q    <= PW'(s4_side_q.org_y) + (s4_py_q >>> FRAC_BITS);
      s5_z_q    <= PW'(s4_side_q.org_z) + (s4_pz_q >>> FRAC_BITS);
      s5_side_q <= s4_side_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: bounds on the two in-plane axes, zero every field on a miss.
  // ---------------------------------------------------------------------------
  logic signed [PW-1:0] pa1;
  logic signed [PW-1:0] pa2;
  logic                 axis_ok;
  logic                 in_box;
  logic                 hit;
  res_t                 res_d;

  always_comb begin
    axis_ok = 1'b1;
    case (plane_axis_q)
      rari_pkg::PLANE_XY: begin pa1 = s5_x_q; pa2 = s5_y_q; end
      rari_pkg::PLANE_XZ: begin pa1 = s5_x_q; pa2 = s5_z_q; end
      rari_pkg::PLANE_YZ: begin pa1 = s5_y_q; pa2 = s5_z_q; end
      default: begin
        pa1     = '0;
        pa2     = '0;
        axis_ok = 1'b0;
      end
    endcase
    in_box = (pa1 >= PW'(first_low_q))  && (pa1 <= PW'(first_high_q)) &&
             (pa2 >= PW'(second_low_q)) && (pa2 <= PW'(second_high_q));
    hit    = axis_ok && in_box && !s5_side_q.miss;

    res_d.hit   = hit;
    res_d.t     = hit ? s5_t_q : '0;
    res_d.px    = hit ? s5_x_q[W-1:0] : '0;
    res_d.py    = hit ? s5_y_q[W-1:0] : '0;
    res_d.pz    = hit ? s5_z_q[W-1:0] : '0;
    res_d.front = hit && s5_side_q.front;
  end

  logic s6_v_q;
  res_t s6_res_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_res_q <= res_d;
    end
  end

  // Valid bits travel with the data and hold with it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
      s6_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= dv_v;
      s4_v_q <= s3_v_q;
      s5_v_q <= s4_v_q;
      s6_v_q <= s5_v_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register plus skid entry. A beat leaving stage 6 while the output
  // is held parks in the skid entry; the pipeline then holds until it drains.
  // ---------------------------------------------------------------------------
  logic out_v_q;
  res_t out_q;
  res_t skid_q;
  logic out_free;
  logic incoming;
  logic out_zero;

  assign out_free = !out_v_q || !out_stall_i;
  assign incoming = en && s6_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_free) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= incoming;
      end
    end else if (incoming) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_v_q ? skid_q : s6_res_q;
    end else if (incoming) begin
      skid_q <= s6_res_q;
    end
  end

  assign out_valid_o  = out_v_q;
  assign hit_o        = out_q.hit;
  assign hit_t_o      = out_q.t;
  assign point_x_o    = out_q.px;
  assign point_y_o    = out_q.py;
  assign point_z_o    = out_q.pz;
  assign front_face_o = out_q.front;

  // All payload fields other than hit are zero.
  assign out_zero = (out_q.t == '0) && (out_q.px == '0) && (out_q.py == '0) &&
                    (out_q.pz == '0) && !out_q.front;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `RARI_ASSERT_IMP(a_miss_fields_zero, out_valid_o && !hit_o, out_zero, "miss beat not zeroed")
  `RARI_ASSERT_IMP(a_skid_behind_out, skid_v_q, out_v_q, "skid full with output empty")
  `RARI_ASSERT_NXT(a_pipe_holds_on_skid, skid_v_q, $stable({s6_v_q, s1_v_q}), "pipe moved")
  `RARI_ASSERT_NXT(a_skid_drains, skid_v_q && !out_stall_i, !skid_v_q && out_v_q, "skid stuck")

endmodule
